// ===== hw/rtl/cubic_disorientation_search_assert.svh =====
// ----------------------------------------------------------------------------
// Cubic disorientation search: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CUBIC_DISORIENTATION_SEARCH_ASSERT_SVH
`define CUBIC_DISORIENTATION_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge of clk, disabled while rstn is low.
`define CDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cds assertion failed");
// Check prop at every rising edge of clk, reset included.
`define CDS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cds assertion failed");
`else
`define CDS_ASSERT(lbl, clk, rstn, prop)
`define CDS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic disorientation search package
// Shared constants, operand select codes and controller command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cds_pkg;

  localparam int MaxSymmDefault   = 24;
  localparam int CompWidthDefault = 16;
  localparam int FracBits         = 14;
  localparam int CountWidth       = 5;
  localparam logic [CountWidth-1:0] SymCountReset = 5'd24;

  // Operand pairing for the shared quaternion multiplier
  typedef enum logic [1:0] {
    MUL_M   = 2'd0,  // B * conj(A)
    MUL_SIM = 2'd1,  // Si * M
    MUL_T   = 2'd2   // (Si * M) * Sj
  } mul_sel_e;

  typedef struct packed {
    logic     tbl_wr;
    logic     start;
    logic     rd_en;
    mul_sel_e sel;
    logic     store_m;
    logic     store_sim;
    logic     eval;
    logic     out_load;
  } cmd_t;

endpackage

// ===== hw/rtl/cds_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cubic disorientation search controller
// Sequences table loads, the symmetry pair loops and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cds_ctrl #(
  parameter int MAX_SYMM = cds_pkg::MaxSymmDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   mode_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [cds_pkg::CountWidth-1:0]         cfg_data_i,
  output cds_pkg::cmd_t                          cmd_o,
  output logic [(MAX_SYMM > 1 ? $clog2(MAX_SYMM) : 1)-1:0] rd_addr_o
);

  localparam int IdxW = (MAX_SYMM > 1) ? $clog2(MAX_SYMM) : 1;
  localparam int CntW = $clog2(MAX_SYMM + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MM1  = 4'd1;
  localparam logic [3:0] S_MM2  = 4'd2;
  localparam logic [3:0] S_MM3  = 4'd3;
  localparam logic [3:0] S_RDI  = 4'd4;
  localparam logic [3:0] S_SI1  = 4'd5;
  localparam logic [3:0] S_SI2  = 4'd6;
  localparam logic [3:0] S_SI3  = 4'd7;
  localparam logic [3:0] S_RDJ  = 4'd8;
  localparam logic [3:0] S_T1   = 4'd9;
  localparam logic [3:0] S_T2   = 4'd10;
  localparam logic [3:0] S_T3   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]                   state_q, state_d;
  logic [IdxW-1:0]              i_q, i_d, j_q, j_d;
  logic [CntW-1:0]              n_q, n_d;
  logic [cds_pkg::CountWidth-1:0] sym_count_q, sym_count_d;
  logic                         out_valid_q, out_valid_d;
  logic                         i_last, j_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  assign i_last = ((CntW'(i_q) + CntW'(1)) == n_q);
  assign j_last = ((CntW'(j_q) + CntW'(1)) == n_q);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    sym_count_d = sym_count_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.sel   = cds_pkg::MUL_M;
    rd_addr_o   = i_q;

    if (cfg_valid_i) begin
      sym_count_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) begin
            cmd_o.tbl_wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            if (int'(sym_count_q) > MAX_SYMM) begin
              n_d = CntW'(MAX_SYMM);
            end else begin
              n_d = CntW'(sym_count_q);
            end
            state_d = S_MM1;
          end
        end
      end
      S_MM1: begin
        cmd_o.sel = cds_pkg::MUL_M;
        state_d   = S_MM2;
      end
      S_MM2: begin
        state_d = S_MM3;
      end
      S_MM3: begin
        cmd_o.store_m = 1'b1;
        i_d           = '0;
        if (n_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RDI;
        end
      end
      S_RDI: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = i_q;
        state_d     = S_SI1;
      end
      S_SI1: begin
        cmd_o.sel = cds_pkg::MUL_SIM;
        state_d   = S_SI2;
      end
      S_SI2: begin
        state_d = S_SI3;
      end
      S_SI3: begin
        cmd_o.store_sim = 1'b1;
        j_d             = '0;
        state_d         = S_RDJ;
      end
      S_RDJ: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = j_q;
        state_d     = S_T1;
      end
      S_T1: begin
        cmd_o.sel = cds_pkg::MUL_T;
        state_d   = S_T2;
      end
      S_T2: begin
        state_d = S_T3;
      end
      S_T3: begin
        cmd_o.eval = 1'b1;
        if (!j_last) begin
          j_d     = j_q + IdxW'(1);
          state_d = S_RDJ;
        end else if (!i_last) begin
          i_d     = i_q + IdxW'(1);
          state_d = S_RDI;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the previous result has been taken
        if (!out_valid_q) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      sym_count_q <= cds_pkg::SymCountReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      sym_count_q <= sym_count_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/cds_dp.sv =====
// ----------------------------------------------------------------------------
// Cubic disorientation search datapath
// Symmetry table, two-stage quaternion multiplier and best-candidate keeper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cds_dp #(
  parameter int MAX_SYMM   = cds_pkg::MaxSymmDefault,
  parameter int COMP_WIDTH = cds_pkg::CompWidthDefault
) (
  input  logic                                   clk_i,
  input  cds_pkg::cmd_t                          cmd_i,
  input  logic [(MAX_SYMM > 1 ? $clog2(MAX_SYMM) : 1)-1:0] rd_addr_i,
  input  logic [4:0]                             sym_index_i,
  input  logic [63:0]                            sym_op_i,
  input  logic [63:0]                            ori_a_i,
  input  logic [63:0]                            ori_b_i,
  output logic signed [15:0]                     mis_x_o,
  output logic signed [15:0]                     mis_y_o,
  output logic signed [15:0]                     mis_z_o,
  output logic signed [15:0]                     mis_w_o,
  output logic                                   found_o
);

  localparam int IdxW = (MAX_SYMM > 1) ? $clog2(MAX_SYMM) : 1;
  // one spare bit so that negation and conjugation stay exact
  localparam int OpW  = (COMP_WIDTH + 1 > 17) ? COMP_WIDTH + 1 : 17;
  localparam int PrdW = 2 * OpW;
  localparam int SumW = PrdW + 2;
  localparam logic signed [SumW-1:0] Half   = SumW'(64'sd1 <<< (cds_pkg::FracBits - 1));
  localparam logic signed [SumW-1:0] CompHi = SumW'((64'sd1 <<< (COMP_WIDTH - 1)) - 1);
  localparam logic signed [SumW-1:0] CompLo = -CompHi - SumW'(1);
  localparam logic signed [OpW-1:0]  OutHi  = OpW'(32767);
  localparam logic signed [OpW-1:0]  OutLo  = -OutHi - OpW'(1);

  logic [63:0]              tbl_q [MAX_SYMM];
  logic [63:0]              rdata_q;
  logic signed [OpW-1:0]    a_q [4];
  logic signed [OpW-1:0]    b_q [4];
  logic signed [OpW-1:0]    m_q [4];
  logic signed [OpW-1:0]    sim_q [4];
  logic signed [OpW-1:0]    s_op [4];
  logic signed [OpW-1:0]    opa [4];
  logic signed [OpW-1:0]    opb [4];
  logic signed [PrdW-1:0]   prod_q [16];
  logic signed [SumW-1:0]   sum [4];
  logic signed [SumW-1:0]   rnd [4];
  logic signed [OpW-1:0]    res_q [4];
  logic signed [OpW-1:0]    cand [4][4];
  logic [3:0]               pass;
  logic signed [OpW-1:0]    best_q [4];
  logic                     found_q;
  logic                     tbl_we;

  function automatic logic signed [OpW-1:0] clamp_out(input logic signed [OpW-1:0] v);
    logic signed [OpW-1:0] r;
    r = (v > OutHi) ? OutHi : ((v < OutLo) ? OutLo : v);
    return r;
  endfunction

  // table: one write port, one registered read port
  assign tbl_we = cmd_i.tbl_wr && (int'(sym_index_i) < MAX_SYMM);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[IdxW'(sym_index_i)] <= sym_op_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= tbl_q[rd_addr_i];
    end
  end

  // capture orientations, A conjugated on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int k = 0; k < 4; k++) begin
        b_q[k] <= OpW'($signed(ori_b_i[16*k +: 16]));
        if (k < 3) begin
          a_q[k] <= -OpW'($signed(ori_a_i[16*k +: 16]));
        end else begin
          a_q[k] <= OpW'($signed(ori_a_i[16*k +: 16]));
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s_op[k] = OpW'($signed(rdata_q[16*k +: 16]));
    end
    unique case (cmd_i.sel)
      cds_pkg::MUL_M: begin
        opa = b_q;
        opb = a_q;
      end
      cds_pkg::MUL_SIM: begin
        opa = s_op;
        opb = m_q;
      end
      cds_pkg::MUL_T: begin
        opa = sim_q;
        opb = s_op;
      end
      default: begin
        opa = b_q;
        opb = a_q;
      end
    endcase
  end

  // stage 1: sixteen partial products
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[4*r+c] <= opa[r] * opb[c];
      end
    end
  end

  // stage 2: Hamilton sums, round half up, saturate
  always_comb begin
    sum[3] = SumW'(prod_q[15]) - SumW'(prod_q[0]) - SumW'(prod_q[5]) - SumW'(prod_q[10]);
    sum[0] = SumW'(prod_q[12]) + SumW'(prod_q[3]) + SumW'(prod_q[6]) - SumW'(prod_q[9]);
    sum[1] = SumW'(prod_q[13]) - SumW'(prod_q[2]) + SumW'(prod_q[7]) + SumW'(prod_q[8]);
    sum[2] = SumW'(prod_q[14]) + SumW'(prod_q[1]) - SumW'(prod_q[4]) + SumW'(prod_q[11]);
    for (int k = 0; k < 4; k++) begin
      rnd[k] = (sum[k] + Half) >>> cds_pkg::FracBits;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (rnd[k] > CompHi) begin
        res_q[k] <= OpW'(CompHi);
      end else if (rnd[k] < CompLo) begin
        res_q[k] <= OpW'(CompLo);
      end else begin
        res_q[k] <= OpW'(rnd[k]);
      end
    end
    if (cmd_i.store_m) begin
      m_q <= res_q;
    end
    if (cmd_i.store_sim) begin
      sim_q <= res_q;
    end
  end

  // four sign variants: -conj(T), -T, conj(T), T
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cand[0][k] = res_q[k];
      cand[1][k] = -res_q[k];
      cand[2][k] = -res_q[k];
      cand[3][k] = res_q[k];
    end
    cand[0][3] = -res_q[3];
    cand[1][3] = -res_q[3];
    cand[2][3] = res_q[3];
    cand[3][3] = res_q[3];
    for (int v = 0; v < 4; v++) begin
      pass[v] = (cand[v][0] >= 0) && (cand[v][0] <= cand[v][1]) &&
                (cand[v][1] <= cand[v][2]) && (cand[v][2] <= cand[v][3]) &&
                (cand[v][3] > best_q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int k = 0; k < 4; k++) begin
        best_q[k] <= '0;
      end
      found_q <= 1'b0;
    end else if (cmd_i.eval && (pass != 4'b0000)) begin
      found_q <= 1'b1;
      priority if (pass[0]) begin
        best_q <= cand[0];
      end else if (pass[1]) begin
        best_q <= cand[1];
      end else if (pass[2]) begin
        best_q <= cand[2];
      end else begin
        best_q <= cand[3];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mis_x_o <= 16'(clamp_out(best_q[0]));
      mis_y_o <= 16'(clamp_out(best_q[1]));
      mis_z_o <= 16'(clamp_out(best_q[2]));
      mis_w_o <= 16'(clamp_out(best_q[3]));
      found_o <= found_q;
    end
  end

endmodule

// ===== hw/rtl/cubic_disorientation_search.sv =====
// ----------------------------------------------------------------------------
// Cubic disorientation search
// A load transfer (mode 0) writes one symmetry quaternion into the table and
// returns nothing; a compute transfer (mode 1) returns one result: the
// candidate Si * (B * conj(A)) * Sj, in one of its four sign variants, that
// lies in 0 <= x <= y <= z <= w with the largest w, or zero with found
// cleared. All values are Q1.14. A compute covers every pair of the n
// operators in use: the single two-stage quaternion multiplier is shared by
// every product, and each symmetry pair takes one table read, the two
// multiplier stages and a compare. Read only table slots that were loaded.
// A finished result waits in the output register while new loads are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cubic_disorientation_search_assert.svh"

module cubic_disorientation_search #(
  parameter int MAX_SYMM   = cds_pkg::MaxSymmDefault,
  parameter int COMP_WIDTH = cds_pkg::CompWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [4:0]                     sym_index_i,
  input  logic [63:0]                    sym_op_i,
  input  logic [63:0]                    ori_a_i,
  input  logic [63:0]                    ori_b_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             mis_x_o,
  output logic signed [15:0]             mis_y_o,
  output logic signed [15:0]             mis_z_o,
  output logic signed [15:0]             mis_w_o,
  output logic                           found_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cds_pkg::CountWidth-1:0] cfg_data_i
);

  localparam int IdxW = (MAX_SYMM > 1) ? $clog2(MAX_SYMM) : 1;

  cds_pkg::cmd_t   cmd;
  logic [IdxW-1:0] rd_addr;

  // controller: operator count register, pair counters, result hand-off
  cds_ctrl #(
    .MAX_SYMM (MAX_SYMM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  // datapath: table, multiplier, candidate compare and output register
  cds_dp #(
    .MAX_SYMM   (MAX_SYMM),
    .COMP_WIDTH (COMP_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .sym_index_i (sym_index_i),
    .sym_op_i    (sym_op_i),
    .ori_a_i     (ori_a_i),
    .ori_b_i     (ori_b_i),
    .mis_x_o     (mis_x_o),
    .mis_y_o     (mis_y_o),
    .mis_z_o     (mis_z_o),
    .mis_w_o     (mis_w_o),
    .found_o     (found_o)
  );

  // a new result never overwrites one still waiting
  `CDS_ASSERT(a_load_free, clk_i, rst_ni, cmd.out_load |-> !out_valid_o)
  // a compute transfer closes the input until its result is loaded into the output register
  `CDS_ASSERT(a_busy, clk_i, rst_ni, (in_valid_i && in_ready_o && mode_i) |=> !in_ready_o)
  // a load transfer leaves the input open
  `CDS_ASSERT(a_load_open, clk_i, rst_ni, (in_valid_i && in_ready_o && !mode_i) |=> in_ready_o)
  // reset drops any pending result at once
  `CDS_ASSERT_ALWAYS(a_rst_clear, clk_i, !rst_ni |-> !out_valid_o)

endmodule
